/* hw/rtl/point_circle_contact_gap_top_macros.svh */
// ----------------------------------------------------------------------------
// Point-circle contact gap: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_CIRCLE_CONTACT_GAP_TOP_MACROS_SVH
`define POINT_CIRCLE_CONTACT_GAP_TOP_MACROS_SVH

// Implication checked in the same cycle
`define PCCG_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pccg implication check failed");

// Condition that must hold at every edge
`define PCCG_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pccg invariant check failed");

`endif

/* hw/rtl/pccg_pkg.sv */
// ----------------------------------------------------------------------------
// pccg_pkg
// Shared constants and register codes for the point-circle contact gap block.
// ----------------------------------------------------------------------------
`default_nettype none

package pccg_pkg;

	localparam int COORD_WIDTH      = 32;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int CFG_IDX_W        = 2;
	localparam int RADIUS_RESET     = 65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X  = 2'd0,
		REG_CENTER_Z  = 2'd1,
		REG_RADIUS    = 2'd2,
		REG_TOLERANCE = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

/* hw/rtl/pccg_sqrt.sv */
// ----------------------------------------------------------------------------
// pccg_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module pccg_sqrt #(
	parameter int IN_W   = 66,
	parameter int SIDE_W = 68
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [IN_W-1:0]     radicand,
	input  wire logic [SIDE_W-1:0]   side_in,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [IN_W/2-1:0]        root,
	output logic [SIDE_W-1:0]        side_out
);

	localparam int QW = IN_W / 2;
	localparam int RW = QW + 3;
	localparam int NS = QW;

	logic              v_s    [NS];
	logic [RW-1:0]     rem_s  [NS];
	logic [QW-1:0]     root_s [NS];
	logic [IN_W-1:0]   rad_s  [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic              rdy    [NS+1];

	assign rdy[NS] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic              v_in;
		logic [RW-1:0]     r_in;
		logic [QW-1:0]     q_in;
		logic [IN_W-1:0]   n_in;
		logic [SIDE_W-1:0] sd_in;
		logic [RW-1:0]     rr;
		logic [RW-1:0]     trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = '0;
			assign q_in  = '0;
			assign n_in  = radicand;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign r_in  = rem_s[k-1];
			assign q_in  = root_s[k-1];
			assign n_in  = rad_s[k-1];
			assign sd_in = side_s[k-1];
		end

		// bubble collapse: a stage loads when empty or when it drains
		assign rdy[k] = !v_s[k] || rdy[k+1];

		// bring down two bits, try the next root bit
		always_comb begin
			rr    = {r_in[RW-3:0], n_in[IN_W-1 -: 2]};
			trial = {1'b0, q_in, 2'b01};
			ge    = (rr >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= ge ? (rr - trial) : rr;
				root_s[k] <= {q_in[QW-2:0], ge};
				rad_s[k]  <= {n_in[IN_W-3:0], 2'b00};
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign root      = root_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

`default_nettype wire

/* hw/rtl/pccg_div.sv */
// ----------------------------------------------------------------------------
// pccg_div
// Pipelined dual restoring divider: rounded unit fractions mag/d for x and z.
// ----------------------------------------------------------------------------
`default_nettype none

module pccg_div #(
	parameter int DW     = 33,
	parameter int NFB    = 14,
	parameter int SIDE_W = 36
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DW-1:0]     divisor,
	input  wire logic [DW-1:0]     mag_x,
	input  wire logic [DW-1:0]     mag_z,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [NFB+1:0]         quot_x,
	output logic [NFB+1:0]         quot_z,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int QN = NFB + 2;
	localparam int NS = NFB + 2;

	logic              v_s    [NS];
	logic [DW-1:0]     d_s    [NS];
	logic [DW-1:0]     rx_s   [NS];
	logic [DW-1:0]     rz_s   [NS];
	logic [QN-1:0]     qx_s   [NS];
	logic [QN-1:0]     qz_s   [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic              rdy    [NS+1];

	assign rdy[NS]  = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic              v_in;
		logic [DW-1:0]     d_in;
		logic [DW-1:0]     rx_in;
		logic [DW-1:0]     rz_in;
		logic [QN-1:0]     qx_in;
		logic [QN-1:0]     qz_in;
		logic [SIDE_W-1:0] sd_in;
		logic [DW:0]       sx;
		logic [DW:0]       sz;
		logic              gex;
		logic              gez;
		logic [DW:0]       nx;
		logic [DW:0]       nz;
		logic [QN-1:0]     qx_n;
		logic [QN-1:0]     qz_n;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign d_in  = divisor;
			assign rx_in = mag_x;
			assign rz_in = mag_z;
			assign qx_in = '0;
			assign qz_in = '0;
			assign sd_in = side_in;
			// integer bit: no shift of the partial remainder
			assign sx = {1'b0, rx_in};
			assign sz = {1'b0, rz_in};
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign d_in  = d_s[k-1];
			assign rx_in = rx_s[k-1];
			assign rz_in = rz_s[k-1];
			assign qx_in = qx_s[k-1];
			assign qz_in = qz_s[k-1];
			assign sd_in = side_s[k-1];
			assign sx = {rx_in, 1'b0};
			assign sz = {rz_in, 1'b0};
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];

		// compare and subtract; the last stage rounds instead of shifting
		always_comb begin
			gex = (sx >= {1'b0, d_in});
			gez = (sz >= {1'b0, d_in});
			nx  = gex ? (sx - {1'b0, d_in}) : sx;
			nz  = gez ? (sz - {1'b0, d_in}) : sz;
			if (k == NS - 1) begin
				qx_n = qx_in + QN'(gex);
				qz_n = qz_in + QN'(gez);
			end else begin
				qx_n = {qx_in[QN-2:0], gex};
				qz_n = {qz_in[QN-2:0], gez};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				d_s[k]    <= d_in;
				rx_s[k]   <= nx[DW-1:0];
				rz_s[k]   <= nz[DW-1:0];
				qx_s[k]   <= qx_n;
				qz_s[k]   <= qz_n;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign quot_x    = qx_s[NS-1];
	assign quot_z    = qz_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

`default_nettype wire

/* hw/rtl/point_circle_contact_gap_top.sv */
// Throughput: one point per cycle while out_stall is low; each stage holds one request
// and loads when empty or when it drains. Depth is set by the front end, the square root
// (one bit per stage), the divider (one bit per stage, last rounds) and output register.
// Reset clears all stage valid bits and loads the register defaults (radius = 65536).
// ----------------------------------------------------------------------------
// point_circle_contact_gap_top
// Streams points, reports contact, gap, unit normal and tangent against a circle.
// ----------------------------------------------------------------------------
`default_nettype none

module point_circle_contact_gap_top #(
	parameter int COORD_WIDTH      = pccg_pkg::COORD_WIDTH,
	parameter int NORMAL_FRAC_BITS = pccg_pkg::NORMAL_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pccg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [COORD_WIDTH-1:0]              cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [COORD_WIDTH-1:0]       point_x,
	input  wire logic signed [COORD_WIDTH-1:0]       point_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     in_contact,
	output logic signed [COORD_WIDTH-1:0]            gap,
	output logic signed [NORMAL_FRAC_BITS+1:0]       normal_x,
	output logic signed [NORMAL_FRAC_BITS+1:0]       normal_z,
	output logic signed [NORMAL_FRAC_BITS+1:0]       tangent_x,
	output logic signed [NORMAL_FRAC_BITS+1:0]       tangent_z
);

	`include "point_circle_contact_gap_top_macros.svh"

	localparam int CW   = COORD_WIDTH;
	localparam int NFB  = NORMAL_FRAC_BITS;
	localparam int NW   = NFB + 2;
	localparam int DW   = CW + 1;
	localparam int SQW  = 2 * DW;
	localparam int GW   = CW + 2;
	localparam int SSW  = 2 + 2 * DW;
	localparam int DSW  = 4 + CW;
	localparam logic signed [NW-1:0] ONE_N = NW'(1) << NFB;

	// configuration registers
	logic signed [CW-1:0] cx_q;
	logic signed [CW-1:0] cz_q;
	logic [CW-2:0]        rad_q;
	logic signed [CW-1:0] tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cz_q  <= '0;
			rad_q <= (CW-1)'(pccg_pkg::RADIUS_RESET);
			tol_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pccg_pkg::cfg_reg_t'(cfg_index))
				pccg_pkg::REG_CENTER_X:  cx_q  <= cfg_data;
				pccg_pkg::REG_CENTER_Z:  cz_q  <= cfg_data;
				pccg_pkg::REG_RADIUS:    rad_q <= cfg_data[CW-2:0];
				pccg_pkg::REG_TOLERANCE: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: offset, magnitude, squares, sum
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic signed [DW-1:0] dx_s1, dz_s1;
	logic [DW-1:0]        mx_s2, mz_s2, mx_s3, mz_s3, mx_s4, mz_s4;
	logic                 sx_s2, sz_s2, sx_s3, sz_s3, sx_s4, sz_s4;
	logic [SQW-1:0]       sqx_s3, sqz_s3, sum_s4;
	logic                 sq_in_ready;

	assign rdy_s4   = !v_s4 || sq_in_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			dx_s1 <= {point_x[CW-1], point_x} - {cx_q[CW-1], cx_q};
			dz_s1 <= {point_z[CW-1], point_z} - {cz_q[CW-1], cz_q};
		end
		if (rdy_s2) begin
			mx_s2 <= dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
			mz_s2 <= dz_s1[DW-1] ? DW'(-dz_s1) : DW'(dz_s1);
			sx_s2 <= dx_s1[DW-1];
			sz_s2 <= dz_s1[DW-1];
		end
		if (rdy_s3) begin
			sqx_s3 <= SQW'(mx_s2) * SQW'(mx_s2);
			sqz_s3 <= SQW'(mz_s2) * SQW'(mz_s2);
			mx_s3  <= mx_s2;
			mz_s3  <= mz_s2;
			sx_s3  <= sx_s2;
			sz_s3  <= sz_s2;
		end
		if (rdy_s4) begin
			sum_s4 <= sqx_s3 + sqz_s3;
			mx_s4  <= mx_s3;
			mz_s4  <= mz_s3;
			sx_s4  <= sx_s3;
			sz_s4  <= sz_s3;
		end
	end

	// distance
	logic           sq_out_valid, dv_in_ready;
	logic [DW-1:0]  distance;
	logic [SSW-1:0] sq_side;

	pccg_sqrt #(
		.IN_W   (SQW),
		.SIDE_W (SSW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (sq_in_ready),
		.radicand  (sum_s4),
		.side_in   ({sx_s4, sz_s4, mx_s4, mz_s4}),
		.out_valid (sq_out_valid),
		.out_ready (dv_in_ready),
		.root      (distance),
		.side_out  (sq_side)
	);

	// gap, contact decision and saturation
	logic signed [GW-1:0] gfull;
	logic signed [GW-1:0] tol_ext;
	logic                 contact, dnz;
	logic [CW-1:0]        gap_sat;

	always_comb begin
		gfull   = $signed({1'b0, distance}) - $signed({3'b000, rad_q});
		tol_ext = {{2{tol_q[CW-1]}}, tol_q};
		contact = (gfull <= tol_ext);
		dnz     = |distance;
		if (gfull[GW-1:CW-1] == '0 || gfull[GW-1:CW-1] == '1) begin
			gap_sat = gfull[CW-1:0];
		end else if (gfull[GW-1]) begin
			gap_sat = {1'b1, {(CW-1){1'b0}}};
		end else begin
			gap_sat = {1'b0, {(CW-1){1'b1}}};
		end
	end

	// unit normal
	logic           dv_out_valid, out_rdy;
	logic [NW-1:0]  qx, qz;
	logic [DSW-1:0] dv_side;

	pccg_div #(
		.DW     (DW),
		.NFB    (NFB),
		.SIDE_W (DSW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_out_valid),
		.in_ready  (dv_in_ready),
		.divisor   (distance),
		.mag_x     (sq_side[2*DW-1:DW]),
		.mag_z     (sq_side[DW-1:0]),
		.side_in   ({sq_side[SSW-1], sq_side[SSW-2], contact, dnz, gap_sat}),
		.out_valid (dv_out_valid),
		.out_ready (out_rdy),
		.quot_x    (qx),
		.quot_z    (qz),
		.side_out  (dv_side)
	);

	// output register: signs, tangent, zero when no contact or zero distance
	logic                 o_sx, o_sz, o_contact, o_dnz, o_keep;
	logic signed [NW-1:0] nx, nz;

	assign out_rdy = !out_valid || !out_stall;

	always_comb begin
		o_sx      = dv_side[DSW-1];
		o_sz      = dv_side[DSW-2];
		o_contact = dv_side[DSW-3];
		o_dnz     = dv_side[DSW-4];
		o_keep    = o_contact && o_dnz;
		nx        = o_sx ? -$signed(qx) : $signed(qx);
		nz        = o_sz ? -$signed(qz) : $signed(qz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_rdy) begin
			out_valid <= dv_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			in_contact <= o_contact;
			gap        <= o_keep ? dv_side[CW-1:0] : '0;
			normal_x   <= o_keep ? nx : '0;
			normal_z   <= o_keep ? nz : '0;
			tangent_x  <= o_keep ? -nz : '0;
			tangent_z  <= (o_keep && nz != '0) ? nx : '0;
		end
	end

	// checks
	`PCCG_ASSERT_IMPL(a_empty_out_takes_input, !out_valid, !in_stall)
	`PCCG_ASSERT_IMPL(a_no_contact_zero, out_valid && !in_contact,
		gap == '0 && normal_x == '0 && normal_z == '0 && tangent_z == '0)
	`PCCG_ASSERT_IMPL(a_tangent_x, out_valid, tangent_x == -normal_z)
	`PCCG_ASSERT_ALWAYS(a_normal_range, !out_valid ||
		(normal_x <= ONE_N && normal_x >= -ONE_N && normal_z <= ONE_N && normal_z >= -ONE_N))

endmodule

`default_nettype wire
